@@ rtl/core/gdec_pkg.sv @@
// ============================================================================
// gdec_pkg - shared types and constants of the gesture decoder
// Register codes, command codes and the per-side status bundle.
// ============================================================================
package gdec_pkg;

    // Width of every timing register on the configuration port
    localparam int unsigned CFG_WIDTH     = 16;
    localparam int unsigned CFG_IDX_WIDTH = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_DEBOUNCE  = 3'd0,
        CFG_SHORT_MAX = 3'd1,
        CFG_LONG_MIN  = 3'd2,
        CFG_COOLDOWN  = 3'd3,
        CFG_SWAP      = 3'd4
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST  = 16'd50;
    localparam logic [CFG_WIDTH-1:0] SHORT_MAX_RST = 16'd800;
    localparam logic [CFG_WIDTH-1:0] LONG_MIN_RST  = 16'd1500;
    localparam logic [CFG_WIDTH-1:0] COOLDOWN_RST  = 16'd500;

    // Team command codes
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_PLUS  = 2'd1,
        CMD_MINUS = 2'd2
    } cmd_t;

    // Status of one debounced side for the current tick
    typedef struct packed {
        logic active;       // debounced level after this tick
        logic click;        // press began this tick
        logic under_short;  // press age below the short limit
        logic over_long;    // press age at or above the long limit
    } side_status_t;

    // One result item
    typedef struct packed {
        logic left_level;
        logic right_level;
        logic press_click;
        cmd_t team_a_cmd;
        cmd_t team_b_cmd;
        logic reset_cmd;
    } result_t;

endpackage

@@ rtl/core/gdec_in_if.sv @@
// ============================================================================
// gdec_in_if - tick request channel
// Valid/ready channel carrying the two raw active-low sensor levels.
// ============================================================================
interface gdec_in_if;
    logic valid;
    logic ready;
    logic raw_left;
    logic raw_right;

    modport source (output valid, output raw_left, output raw_right, input ready);
    modport sink   (input valid, input raw_left, input raw_right, output ready);
endinterface

@@ rtl/core/gdec_out_if.sv @@
// ============================================================================
// gdec_out_if - result channel
// Valid/ready channel carrying debounced levels and decoded commands.
// ============================================================================
interface gdec_out_if;
    logic       valid;
    logic       ready;
    logic       left_level;
    logic       right_level;
    logic       press_click;
    logic [1:0] team_a_cmd;
    logic [1:0] team_b_cmd;
    logic       reset_cmd;

    modport source (
        output valid, output left_level, output right_level, output press_click,
        output team_a_cmd, output team_b_cmd, output reset_cmd, input ready
    );
    modport sink (
        input valid, input left_level, input right_level, input press_click,
        input team_a_cmd, input team_b_cmd, input reset_cmd, output ready
    );
endinterface

@@ rtl/core/dual_button_gesture_decoder_unit.sv @@
// ============================================================================
// dual_button_gesture_decoder_unit - two-sensor press gesture decoder
// Debounces two sensors per tick and decodes plus, minus and reset gestures.
// ============================================================================
//
//   channel   dir   handshake          payload
//   tick      in    valid / ready      raw_left, raw_right (active low)
//   gesture   out   valid / ready      levels, press_click, team cmds, reset
//   wr_*      in    wr_en (no wait)    wr_index, wr_data[15:0]
//
// Every tick request yields exactly one result. A request lands in the input
// register, is decoded from there and lands in the result register; one
// request is taken every cycle while results drain. The result register is
// the only thing that stalls: while it is full and not taken, the input
// register holds and tick.ready falls once it is also full. Reset clears all
// tick state; the first cooldown_ms ticks after reset sit inside the command
// cooldown.
//
module dual_button_gesture_decoder_unit #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    gdec_in_if.sink                             tick,
    gdec_out_if.source                          gesture,
    input  logic                                wr_en,
    input  logic [gdec_pkg::CFG_IDX_WIDTH-1:0]  wr_index,
    input  logic [gdec_pkg::CFG_WIDTH-1:0]      wr_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [gdec_pkg::CFG_WIDTH-1:0] debounce_reg;
    logic [gdec_pkg::CFG_WIDTH-1:0] short_max_reg;
    logic [gdec_pkg::CFG_WIDTH-1:0] long_min_reg;
    logic [gdec_pkg::CFG_WIDTH-1:0] cooldown_reg;
    logic                           swap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= gdec_pkg::DEBOUNCE_RST;
            short_max_reg <= gdec_pkg::SHORT_MAX_RST;
            long_min_reg  <= gdec_pkg::LONG_MIN_RST;
            cooldown_reg  <= gdec_pkg::COOLDOWN_RST;
            swap_reg      <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (gdec_pkg::cfg_idx_t'(wr_index))
                gdec_pkg::CFG_DEBOUNCE:  debounce_reg  <= wr_data;
                gdec_pkg::CFG_SHORT_MAX: short_max_reg <= wr_data;
                gdec_pkg::CFG_LONG_MIN:  long_min_reg  <= wr_data;
                gdec_pkg::CFG_COOLDOWN:  cooldown_reg  <= wr_data;
                gdec_pkg::CFG_SWAP:      swap_reg      <= wr_data[0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register and flow control
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic in_raw_left_reg;
    logic in_raw_right_reg;
    logic out_valid_reg;
    logic advance;

    // Decode the held request when the result register is free or draining
    assign advance    = in_valid_reg && (!out_valid_reg || gesture.ready);
    assign tick.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            in_raw_left_reg  <= tick.raw_left;
            in_raw_right_reg <= tick.raw_right;
        end
    end

    // ------------------------------------------------------------------
    // Tick time and per-side debouncers
    // ------------------------------------------------------------------
    logic [TIME_WIDTH-1:0] tick_count_reg;
    logic [TIME_WIDTH-1:0] now;

    assign now = tick_count_reg;

    gdec_pkg::side_status_t left_st;
    gdec_pkg::side_status_t right_st;

    gdec_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_left (
        .clk                (clk),
        .rst_n              (rst_n),
        .advance            (advance),
        .raw                (in_raw_left_reg),
        .now                (now),
        .settle_limit       (debounce_reg),
        .short_press_max_ms (short_max_reg),
        .long_press_min_ms  (long_min_reg),
        .status             (left_st)
    );

    gdec_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_right (
        .clk                (clk),
        .rst_n              (rst_n),
        .advance            (advance),
        .raw                (in_raw_right_reg),
        .now                (now),
        .settle_limit       (debounce_reg),
        .short_press_max_ms (short_max_reg),
        .long_press_min_ms  (long_min_reg),
        .status             (right_st)
    );

    // ------------------------------------------------------------------
    // Gesture state
    // ------------------------------------------------------------------
    logic                  left_pending_reg,  left_pending_next;
    logic                  right_pending_reg, right_pending_next;
    logic                  left_done_reg,     left_done_next;
    logic                  right_done_reg,    right_done_next;
    logic [TIME_WIDTH-1:0] dual_hold_time_reg, dual_hold_time_next;
    logic                  dual_holding_reg,   dual_holding_next;
    logic                  dual_done_reg,      dual_done_next;
    logic [TIME_WIDTH-1:0] last_cmd_time_reg,  last_cmd_time_next;

    logic                  cooldown_over;
    logic                  dual_long;
    logic [TIME_WIDTH-1:0] dual_base;
    gdec_pkg::cmd_t        cmd_a;
    gdec_pkg::cmd_t        cmd_b;
    logic                  cmd_reset;
    gdec_pkg::result_t     result_next;

    assign cooldown_over = (now - last_cmd_time_reg) >= TIME_WIDTH'(cooldown_reg);

    // A dual hold that starts this tick has age zero
    assign dual_base = dual_holding_reg ? dual_hold_time_reg : now;
    assign dual_long = (now - dual_base) >= TIME_WIDTH'(long_min_reg);

    always_comb
    begin
        // A fresh press arms its side
        left_pending_next   = left_pending_reg  || left_st.click;
        left_done_next      = left_done_reg     && !left_st.click;
        right_pending_next  = right_pending_reg || right_st.click;
        right_done_next     = right_done_reg    && !right_st.click;
        dual_hold_time_next = dual_hold_time_reg;
        dual_holding_next   = dual_holding_reg;
        dual_done_next      = dual_done_reg;
        last_cmd_time_next  = last_cmd_time_reg;
        cmd_a               = gdec_pkg::CMD_NONE;
        cmd_b               = gdec_pkg::CMD_NONE;
        cmd_reset           = 1'b0;

        if (cooldown_over)
        begin
            if (left_st.active && right_st.active)
            begin
                // Both held: time the dual hold toward a reset
                if (!dual_holding_reg)
                begin
                    dual_holding_next   = 1'b1;
                    dual_hold_time_next = now;
                end
                if (!dual_done_reg && dual_long)
                begin
                    cmd_reset          = 1'b1;
                    last_cmd_time_next = now;
                    dual_done_next     = 1'b1;
                    left_done_next     = 1'b1;
                    right_done_next    = 1'b1;
                end
            end
            else
            begin
                dual_holding_next = 1'b0;
                if (!left_st.active && !right_st.active)
                begin
                    dual_done_next = 1'b0;
                end

                // Left release: plus on a short lone press
                if (!left_st.active && left_pending_next && !left_done_next)
                begin
                    if (!right_st.active && left_st.under_short)
                    begin
                        cmd_a              = gdec_pkg::CMD_PLUS;
                        last_cmd_time_next = now;
                    end
                    left_done_next    = 1'b1;
                    left_pending_next = 1'b0;
                end
                // Left lone long hold: minus
                if (left_st.active && !left_done_next && !right_st.active &&
                    left_st.over_long)
                begin
                    cmd_a              = gdec_pkg::CMD_MINUS;
                    last_cmd_time_next = now;
                    left_done_next     = 1'b1;
                end

                // Right release: plus on a short lone press
                if (!right_st.active && right_pending_next && !right_done_next)
                begin
                    if (!left_st.active && right_st.under_short)
                    begin
                        cmd_b              = gdec_pkg::CMD_PLUS;
                        last_cmd_time_next = now;
                    end
                    right_done_next    = 1'b1;
                    right_pending_next = 1'b0;
                end
                // Right lone long hold: minus
                if (right_st.active && !right_done_next && !left_st.active &&
                    right_st.over_long)
                begin
                    cmd_b              = gdec_pkg::CMD_MINUS;
                    last_cmd_time_next = now;
                    right_done_next    = 1'b1;
                end
            end
        end

        result_next.left_level  = left_st.active;
        result_next.right_level = right_st.active;
        result_next.press_click = left_st.click || right_st.click;
        result_next.team_a_cmd  = swap_reg ? cmd_b : cmd_a;
        result_next.team_b_cmd  = swap_reg ? cmd_a : cmd_b;
        result_next.reset_cmd   = cmd_reset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg     <= '0;
            left_pending_reg   <= 1'b0;
            right_pending_reg  <= 1'b0;
            left_done_reg      <= 1'b0;
            right_done_reg     <= 1'b0;
            dual_hold_time_reg <= '0;
            dual_holding_reg   <= 1'b0;
            dual_done_reg      <= 1'b0;
            last_cmd_time_reg  <= '0;
        end
        else if (advance)
        begin
            tick_count_reg     <= tick_count_reg + 1'b1;
            left_pending_reg   <= left_pending_next;
            right_pending_reg  <= right_pending_next;
            left_done_reg      <= left_done_next;
            right_done_reg     <= right_done_next;
            dual_hold_time_reg <= dual_hold_time_next;
            dual_holding_reg   <= dual_holding_next;
            dual_done_reg      <= dual_done_next;
            last_cmd_time_reg  <= last_cmd_time_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    gdec_pkg::result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (gesture.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign gesture.valid       = out_valid_reg;
    assign gesture.left_level  = result_reg.left_level;
    assign gesture.right_level = result_reg.right_level;
    assign gesture.press_click = result_reg.press_click;
    assign gesture.team_a_cmd  = result_reg.team_a_cmd;
    assign gesture.team_b_cmd  = result_reg.team_b_cmd;
    assign gesture.reset_cmd   = result_reg.reset_cmd;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A reset result carries no team command
    a_reset_no_team: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.reset_cmd) |->
            (result_reg.team_a_cmd == gdec_pkg::CMD_NONE &&
             result_reg.team_b_cmd == gdec_pkg::CMD_NONE))
        else $error("reset command with a team command");

    // A reset result needs both debounced levels held
    a_reset_both_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.reset_cmd) |->
            (result_reg.left_level && result_reg.right_level))
        else $error("reset command without both sides held");

    // Any emitted command restarts the cooldown at the current tick
    a_cmd_restarts_cooldown: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cmd_reset || cmd_a != gdec_pkg::CMD_NONE ||
                     cmd_b != gdec_pkg::CMD_NONE)) |=>
            (last_cmd_time_reg == $past(tick_count_reg)))
        else $error("command did not restart cooldown");

    // Tick time advances once per decoded request
    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (tick_count_reg == $past(tick_count_reg) + 1'b1))
        else $error("tick count did not advance");

endmodule

@@ rtl/core/gdec_debounce.sv @@
// ============================================================================
// gdec_debounce - one sensor debouncer with press timing
// Tracks settle time, debounced level and press start of one sensor.
// ============================================================================
module gdec_debounce #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic                             raw,
    input  logic [TIME_WIDTH-1:0]            now,
    input  logic [gdec_pkg::CFG_WIDTH-1:0]   settle_limit,
    input  logic [gdec_pkg::CFG_WIDTH-1:0]   short_press_max_ms,
    input  logic [gdec_pkg::CFG_WIDTH-1:0]   long_press_min_ms,
    output gdec_pkg::side_status_t           status
);

    logic                  prev_reg;
    logic [TIME_WIDTH-1:0] settle_reg;
    logic                  active_reg;
    logic [TIME_WIDTH-1:0] press_time_reg;

    logic [TIME_WIDTH-1:0] settle_next;
    logic [TIME_WIDTH-1:0] press_time_next;
    logic                  active_next;
    logic                  settled;
    logic                  click;
    logic [TIME_WIDTH-1:0] press_age;

    // Restart the settle window on any raw edge
    assign settle_next = (raw != prev_reg) ? now : settle_reg;
    assign settled     = (now - settle_next) > TIME_WIDTH'(settle_limit);
    assign click       = settled && !raw && !active_reg;
    assign active_next = settled ? !raw : active_reg;

    assign press_time_next = click ? now : press_time_reg;
    assign press_age       = now - press_time_next;

    assign status.active      = active_next;
    assign status.click       = click;
    assign status.under_short = press_age < TIME_WIDTH'(short_press_max_ms);
    assign status.over_long   = press_age >= TIME_WIDTH'(long_press_min_ms);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= 1'b1;
            settle_reg     <= '0;
            active_reg     <= 1'b0;
            press_time_reg <= '0;
        end
        else if (advance)
        begin
            prev_reg       <= raw;
            settle_reg     <= settle_next;
            active_reg     <= active_next;
            press_time_reg <= press_time_next;
        end
    end

endmodule
